// ===== sv/ahc_pkg.sv =====
// Shared constants, types and reset-layout functions for the adaptive Huffman codec.
// Used by the channel interfaces, the controller, the datapath and the checker.
`default_nettype none

package ahc_pkg;

  // Alphabet, window and count limits.
  localparam int SYMBOLS     = 256;
  localparam int WINDOW_BITS = 24;
  localparam int COUNT_LIMIT = 134217728;
  localparam int TREE        = 2 * SYMBOLS - 1;
  localparam int ROOT        = TREE - 1;
  localparam int LINKS       = TREE + SYMBOLS;

  // Widths derived from the limits above.
  localparam int SYM_W  = $clog2(SYMBOLS);
  localparam int NODE_W = $clog2(LINKS);
  localparam int ADDR_W = $clog2(TREE + 1);
  localparam int CNT_W  = $clog2(COUNT_LIMIT) + 1;
  localparam int LEN_W  = $clog2(WINDOW_BITS + 1);
  localparam int LCNT_W = $clog2(TREE + 1);

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [ADDR_W-1:0] caddr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LCNT_W-1:0] lcnt_t;

  localparam node_t TREE_IDX  = node_t'(TREE);
  localparam node_t ROOT_IDX  = node_t'(ROOT);
  localparam node_t LINKS_IDX = node_t'(LINKS);
  localparam node_t SYMS_IDX  = node_t'(SYMBOLS);
  localparam cnt_t  LIMIT_CNT = cnt_t'(COUNT_LIMIT);

  // Micro-operations that the controller issues to the datapath.
  typedef enum logic [5:0] {
    OP_INIT, OP_IDLE,
    OP_EN_LEAF, OP_EN_LD, OP_EN_BIT, OP_EN_NEXT,
    OP_DE_ROOT, OP_DE_LD, OP_DE_CHK,
    OP_OUT,
    OP_U_RROOT, OP_U_CHKR, OP_U_LEAF, OP_U_LDC, OP_U_TOP, OP_U_INC,
    OP_U_SCR, OP_U_SCC, OP_U_SWCHK,
    OP_SW_RB, OP_SW_W1, OP_SW_W2, OP_SW_W3, OP_SW_W4,
    OP_U_RCHK, OP_U_NXT,
    OP_RB1_RD, OP_RB1_WR,
    OP_RB2_RA, OP_RB2_RB, OP_RB2_SUM, OP_RB2_ST, OP_RB2_CMP, OP_RB2_PUT,
    OP_RB3_RD, OP_RB3_W1, OP_RB3_W2, OP_RB3_ROOT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic capture;
    logic out_load;
  } ahc_cmd_t;

  typedef struct packed {
    logic mode;
    logic init_last;
    logic k_lt_tree;
    logic len_lt_tree;
    logic len_lt_win;
    logic kp_lt_tree;
    logic pdat_root;
    logic need_rebuild;
    logic steps_lt_tree;
    logic x_lt_root;
    logic f_gt_n;
    logic x_ne_k;
    logic k_is_root;
    logic rb_last;
    logic e_done;
    logic j_gt0;
    logic f_lt_n;
  } ahc_status_t;

  // Reset layout: leaves first, then node SYMBOLS+m over children 2m and 2m+1.
  function automatic node_t init_child(node_t i);
    if (i < SYMS_IDX) return TREE_IDX + i;
    return node_t'((i - SYMS_IDX) << 1);
  endfunction

  function automatic node_t init_parent(node_t i);
    if (i >= TREE_IDX) return i - TREE_IDX;
    if (i == ROOT_IDX) return ROOT_IDX;
    return SYMS_IDX + (i >> 1);
  endfunction

  // Balanced tree counts double at each level; the entry past the tree is the stop value.
  function automatic cnt_t init_count(node_t i);
    cnt_t v;
    v = cnt_t'(1);
    if (i == TREE_IDX) begin
      v = LIMIT_CNT;
    end else begin
      for (int k = 1; k <= SYM_W; k++) begin
        if (int'(i) >= 2 * SYMBOLS - ((2 * SYMBOLS) >> k)) v = cnt_t'(1) << k;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ahc_if.sv =====
// Valid/ready channel interfaces for the codec: input words, result words, mode writes.
// Depends on ahc_pkg for the field widths.
`default_nettype none

interface ahc_in_if;
  logic                              valid;
  logic                              ready;
  logic [ahc_pkg::SYM_W-1:0]         symbol_in;
  logic [ahc_pkg::WINDOW_BITS-1:0]   code_window;
  modport source (output valid, symbol_in, code_window, input ready);
  modport sink   (input valid, symbol_in, code_window, output ready);
endinterface

interface ahc_out_if;
  logic                              valid;
  logic                              ready;
  logic [ahc_pkg::WINDOW_BITS-1:0]   code_value;
  logic [ahc_pkg::LEN_W-1:0]         code_length;
  logic [ahc_pkg::SYM_W-1:0]         symbol_out;
  logic                              too_long;
  modport source (output valid, code_value, code_length, symbol_out, too_long, input ready);
  modport sink   (input valid, code_value, code_length, symbol_out, too_long, output ready);
endinterface

interface ahc_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, mode, input ready);
  modport sink   (input valid, mode, output ready);
endinterface

`default_nettype wire

// ===== sv/ahc_datapath.sv =====
// Datapath of the codec: tree memories, working registers and the result register.
// Executes one micro-operation per cycle from ahc_ctrl; depends on ahc_pkg.
`default_nettype none

module ahc_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ahc_pkg::ahc_cmd_t               cmd,
  output ahc_pkg::ahc_status_t                 st,
  input  wire logic [ahc_pkg::SYM_W-1:0]       symbol_in,
  input  wire logic [ahc_pkg::WINDOW_BITS-1:0] code_window,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_mode,
  output logic [ahc_pkg::WINDOW_BITS-1:0]      code_value,
  output logic [ahc_pkg::LEN_W-1:0]            code_length,
  output logic [ahc_pkg::SYM_W-1:0]            symbol_out,
  output logic                                 too_long
);
  import ahc_pkg::*;

  // Tree storage.
  node_t child_mem  [TREE];
  node_t parent_mem [LINKS];
  cnt_t  count_mem  [TREE + 1];

  // Memory ports.
  caddr_t c_ra, c_wa, n_ra, n_wa;
  node_t  p_ra, p_wa;
  node_t  c_wd, p_wd;
  cnt_t   n_wd;
  logic   c_we, p_we, n_we;
  node_t  cdat_r, pdat_r;
  cnt_t   ndat_r;

  // Working registers.
  logic                   mode_r;
  logic [SYM_W-1:0]       sym_r, sym_nxt;
  logic [WINDOW_BITS-1:0] win_r, win_nxt, code_r, code_nxt;
  lcnt_t                  len_r, len_nxt, steps_r, steps_nxt;
  node_t                  k_r, k_nxt, x_r, x_nxt, a_r, a_nxt, b_r, b_nxt;
  node_t                  i_r, i_nxt, e_r, e_nxt, j_r, j_nxt;
  cnt_t                   f_r, f_nxt;
  logic [WINDOW_BITS-1:0] ov_r, ov_nxt;
  logic [LEN_W-1:0]       ol_r, ol_nxt;
  logic [SYM_W-1:0]       os_r, os_nxt;
  logic                   ot_r, ot_nxt;

  // Helpers.
  node_t                  kp, dsym;
  logic [SYM_W-1:0]       dsym_cap;
  logic [WINDOW_BITS-1:0] win_mask;
  logic [CNT_W:0]         half_sum;
  logic                   enc_long;

  always_comb begin
    kp       = k_r + node_t'(win_r[len_r[LEN_W-1:0]]);
    dsym     = k_r - TREE_IDX;
    dsym_cap = (dsym >= SYMS_IDX) ? SYM_W'(SYMBOLS - 1) : dsym[SYM_W-1:0];
    for (int j = 0; j < WINDOW_BITS; j++) win_mask[j] = (lcnt_t'(j) < len_r);
    half_sum = {1'b0, ndat_r} + (CNT_W + 1)'(1);
    enc_long = (len_r > lcnt_t'(WINDOW_BITS));
  end

  // Status toward the controller.
  always_comb begin
    st.mode          = mode_r;
    st.init_last     = (i_r == LINKS_IDX - node_t'(1));
    st.k_lt_tree     = (k_r < TREE_IDX);
    st.len_lt_tree   = (len_r < lcnt_t'(TREE));
    st.len_lt_win    = (len_r < lcnt_t'(WINDOW_BITS));
    st.kp_lt_tree    = (kp < TREE_IDX);
    st.pdat_root     = (pdat_r == ROOT_IDX);
    st.need_rebuild  = (ndat_r >= LIMIT_CNT);
    st.steps_lt_tree = (steps_r < lcnt_t'(TREE));
    st.x_lt_root     = (x_r < ROOT_IDX);
    st.f_gt_n        = (f_r > ndat_r);
    st.x_ne_k        = (x_r != k_r);
    st.k_is_root     = (k_r == ROOT_IDX);
    st.rb_last       = (i_r == TREE_IDX - node_t'(1));
    st.e_done        = (e_r == TREE_IDX);
    st.j_gt0         = (j_r != '0);
    st.f_lt_n        = (f_r < ndat_r);
  end

  // Micro-operation decode.
  always_comb begin
    c_ra = '0; c_wa = '0; c_wd = '0; c_we = 1'b0;
    n_ra = '0; n_wa = '0; n_wd = '0; n_we = 1'b0;
    p_ra = '0; p_wa = '0; p_wd = '0; p_we = 1'b0;
    sym_nxt = sym_r; win_nxt = win_r; code_nxt = code_r; len_nxt = len_r;
    steps_nxt = steps_r; k_nxt = k_r; x_nxt = x_r; a_nxt = a_r; b_nxt = b_r;
    i_nxt = i_r; e_nxt = e_r; j_nxt = j_r; f_nxt = f_r;
    ov_nxt = ov_r; ol_nxt = ol_r; os_nxt = os_r; ot_nxt = ot_r;
    unique case (cmd.op)
      OP_INIT: begin
        p_we = 1'b1; p_wa = i_r; p_wd = init_parent(i_r);
        c_we = (i_r < TREE_IDX); c_wa = i_r[ADDR_W-1:0]; c_wd = init_child(i_r);
        n_we = (i_r <= TREE_IDX); n_wa = i_r[ADDR_W-1:0]; n_wd = init_count(i_r);
        i_nxt = i_r + node_t'(1);
      end
      OP_IDLE: begin
        if (cmd.capture) begin
          sym_nxt = symbol_in; win_nxt = code_window; code_nxt = '0; len_nxt = '0;
        end
      end
      OP_EN_LEAF: p_ra = TREE_IDX + node_t'(sym_r);
      OP_EN_LD:   k_nxt = pdat_r;
      OP_EN_BIT: begin
        code_nxt = {code_r[WINDOW_BITS-2:0], k_r[0]};
        len_nxt  = len_r + lcnt_t'(1);
        if (k_r < TREE_IDX) p_ra = k_r;
      end
      OP_EN_NEXT: k_nxt = pdat_r;
      OP_DE_ROOT: c_ra = ROOT_IDX[ADDR_W-1:0];
      OP_DE_LD:   k_nxt = cdat_r;
      OP_DE_CHK: begin
        if (st.k_lt_tree && st.len_lt_win) begin
          len_nxt = len_r + lcnt_t'(1);
          if (kp < TREE_IDX) c_ra = kp[ADDR_W-1:0];
          else k_nxt = TREE_IDX;
        end
      end
      OP_OUT: begin
        if (cmd.out_load) begin
          if (!mode_r) begin
            ot_nxt = enc_long;
            ov_nxt = enc_long ? '0 : code_r;
            ol_nxt = enc_long ? '0 : len_r[LEN_W-1:0];
            os_nxt = sym_r;
          end else if (st.k_lt_tree) begin
            ot_nxt = 1'b1; ov_nxt = '0; ol_nxt = '0; os_nxt = '0;
          end else begin
            ot_nxt  = 1'b0;
            ov_nxt  = win_r & win_mask;
            ol_nxt  = len_r[LEN_W-1:0];
            os_nxt  = dsym_cap;
            sym_nxt = dsym_cap;
          end
        end
      end
      OP_U_RROOT: n_ra = ROOT_IDX[ADDR_W-1:0];
      OP_U_CHKR: begin
        i_nxt = '0; e_nxt = '0;
      end
      OP_U_LEAF: p_ra = TREE_IDX + node_t'(sym_r);
      OP_U_LDC: begin
        k_nxt = pdat_r; steps_nxt = '0;
      end
      OP_U_TOP: n_ra = k_r[ADDR_W-1:0];
      OP_U_INC: begin
        f_nxt = ndat_r + cnt_t'(1);
        n_we = 1'b1; n_wa = k_r[ADDR_W-1:0]; n_wd = ndat_r + cnt_t'(1);
        x_nxt = k_r;
      end
      OP_U_SCR: begin
        if (st.x_lt_root) n_ra = x_r[ADDR_W-1:0] + caddr_t'(1);
      end
      OP_U_SCC: begin
        if (st.f_gt_n) x_nxt = x_r + node_t'(1);
      end
      OP_U_SWCHK: c_ra = k_r[ADDR_W-1:0];
      OP_SW_RB: begin
        a_nxt = cdat_r; c_ra = x_r[ADDR_W-1:0]; n_ra = x_r[ADDR_W-1:0];
      end
      OP_SW_W1: begin
        b_nxt = cdat_r;
        c_we = 1'b1; c_wa = k_r[ADDR_W-1:0]; c_wd = cdat_r;
        n_we = 1'b1; n_wa = k_r[ADDR_W-1:0]; n_wd = ndat_r;
        p_we = (a_r < LINKS_IDX); p_wa = a_r; p_wd = x_r;
      end
      OP_SW_W2: begin
        c_we = 1'b1; c_wa = x_r[ADDR_W-1:0]; c_wd = a_r;
        n_we = 1'b1; n_wa = x_r[ADDR_W-1:0]; n_wd = f_r;
        p_we = (a_r < TREE_IDX); p_wa = a_r + node_t'(1); p_wd = x_r;
      end
      OP_SW_W3: begin
        p_we = (b_r < LINKS_IDX); p_wa = b_r; p_wd = k_r;
      end
      OP_SW_W4: begin
        p_we = (b_r < TREE_IDX); p_wa = b_r + node_t'(1); p_wd = k_r;
        k_nxt = x_r;
      end
      OP_U_RCHK: begin
        p_ra = k_r; steps_nxt = steps_r + lcnt_t'(1);
      end
      OP_U_NXT: k_nxt = pdat_r;
      OP_RB1_RD: begin
        c_ra = i_r[ADDR_W-1:0]; n_ra = i_r[ADDR_W-1:0];
      end
      OP_RB1_WR: begin
        if (cdat_r >= TREE_IDX && e_r < SYMS_IDX) begin
          c_we = 1'b1; c_wa = e_r[ADDR_W-1:0]; c_wd = cdat_r;
          n_we = 1'b1; n_wa = e_r[ADDR_W-1:0]; n_wd = half_sum[CNT_W:1];
          e_nxt = e_r + node_t'(1);
        end
        if (st.rb_last) begin
          i_nxt = '0; e_nxt = SYMS_IDX;
        end else begin
          i_nxt = i_r + node_t'(1);
        end
      end
      OP_RB2_RA: begin
        if (st.e_done) i_nxt = '0;
        else n_ra = i_r[ADDR_W-1:0];
      end
      OP_RB2_RB: begin
        f_nxt = ndat_r; n_ra = i_r[ADDR_W-1:0] + caddr_t'(1);
      end
      OP_RB2_SUM: begin
        f_nxt = f_r + ndat_r; j_nxt = e_r;
      end
      OP_RB2_ST: begin
        if (st.j_gt0) begin
          c_ra = j_r[ADDR_W-1:0] - caddr_t'(1); n_ra = j_r[ADDR_W-1:0] - caddr_t'(1);
        end
      end
      OP_RB2_CMP: begin
        if (st.f_lt_n) begin
          c_we = 1'b1; c_wa = j_r[ADDR_W-1:0]; c_wd = cdat_r;
          n_we = 1'b1; n_wa = j_r[ADDR_W-1:0]; n_wd = ndat_r;
          j_nxt = j_r - node_t'(1);
        end
      end
      OP_RB2_PUT: begin
        c_we = 1'b1; c_wa = j_r[ADDR_W-1:0]; c_wd = i_r;
        n_we = 1'b1; n_wa = j_r[ADDR_W-1:0]; n_wd = f_r;
        i_nxt = i_r + node_t'(2); e_nxt = e_r + node_t'(1);
      end
      OP_RB3_RD: c_ra = i_r[ADDR_W-1:0];
      OP_RB3_W1: begin
        a_nxt = cdat_r;
        p_we = (cdat_r < LINKS_IDX); p_wa = cdat_r; p_wd = i_r;
      end
      OP_RB3_W2: begin
        p_we = (a_r < TREE_IDX); p_wa = a_r + node_t'(1); p_wd = i_r;
        i_nxt = i_r + node_t'(1);
      end
      OP_RB3_ROOT: begin
        p_we = 1'b1; p_wa = ROOT_IDX; p_wd = ROOT_IDX;
      end
      default: ;
    endcase
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (c_we) child_mem[c_wa] <= c_wd;
    cdat_r <= child_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) parent_mem[p_wa] <= p_wd;
    pdat_r <= parent_mem[p_ra];
  end

  always_ff @(posedge clk) begin
    if (n_we) count_mem[n_wa] <= n_wd;
    ndat_r <= count_mem[n_ra];
  end

  // Control registers: mode and the sweep index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      i_r    <= '0;
    end else begin
      if (cfg_we) mode_r <= cfg_mode;
      i_r <= i_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sym_r <= sym_nxt; win_r <= win_nxt; code_r <= code_nxt; len_r <= len_nxt;
    steps_r <= steps_nxt; k_r <= k_nxt; x_r <= x_nxt; a_r <= a_nxt; b_r <= b_nxt;
    e_r <= e_nxt; j_r <= j_nxt; f_r <= f_nxt;
    ov_r <= ov_nxt; ol_r <= ol_nxt; os_r <= os_nxt; ot_r <= ot_nxt;
  end

  assign code_value  = ov_r;
  assign code_length = ol_r;
  assign symbol_out  = os_r;
  assign too_long    = ot_r;

endmodule

`default_nettype wire

// ===== sv/ahc_ctrl.sv =====
// Sequencer of the codec: walks encode, decode, update and rebuild one step per state.
// Drives ahc_datapath with micro-operations; owns the handshakes. Depends on ahc_pkg.
`default_nettype none

module ahc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ahc_pkg::ahc_status_t st,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output ahc_pkg::ahc_cmd_t         cmd
);
  import ahc_pkg::*;

  typedef enum logic [37:0] {
    S_INIT     = 38'h1 << 0,  S_IDLE     = 38'h1 << 1,
    S_EN_LEAF  = 38'h1 << 2,  S_EN_LD    = 38'h1 << 3,
    S_EN_BIT   = 38'h1 << 4,  S_EN_NEXT  = 38'h1 << 5,
    S_DE_ROOT  = 38'h1 << 6,  S_DE_LD    = 38'h1 << 7,
    S_DE_CHK   = 38'h1 << 8,  S_OUT      = 38'h1 << 9,
    S_U_RROOT  = 38'h1 << 10, S_U_CHKR   = 38'h1 << 11,
    S_U_LEAF   = 38'h1 << 12, S_U_LDC    = 38'h1 << 13,
    S_U_TOP    = 38'h1 << 14, S_U_INC    = 38'h1 << 15,
    S_U_SCR    = 38'h1 << 16, S_U_SCC    = 38'h1 << 17,
    S_U_SWCHK  = 38'h1 << 18, S_SW_RB    = 38'h1 << 19,
    S_SW_W1    = 38'h1 << 20, S_SW_W2    = 38'h1 << 21,
    S_SW_W3    = 38'h1 << 22, S_SW_W4    = 38'h1 << 23,
    S_U_RCHK   = 38'h1 << 24, S_U_NXT    = 38'h1 << 25,
    S_RB1_RD   = 38'h1 << 26, S_RB1_WR   = 38'h1 << 27,
    S_RB2_RA   = 38'h1 << 28, S_RB2_RB   = 38'h1 << 29,
    S_RB2_SUM  = 38'h1 << 30, S_RB2_ST   = 38'h1 << 31,
    S_RB2_CMP  = 38'h1 << 32, S_RB2_PUT  = 38'h1 << 33,
    S_RB3_RD   = 38'h1 << 34, S_RB3_W1   = 38'h1 << 35,
    S_RB3_W2   = 38'h1 << 36, S_RB3_ROOT = 38'h1 << 37
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command.
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_IDLE;
    cmd.capture  = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_INIT;
        if (st.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.op = OP_IDLE;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = st.mode ? S_DE_ROOT : S_EN_LEAF;
      end
      S_EN_LEAF: begin cmd.op = OP_EN_LEAF; state_nxt = S_EN_LD; end
      S_EN_LD:   begin cmd.op = OP_EN_LD;   state_nxt = S_EN_BIT; end
      S_EN_BIT: begin
        cmd.op = OP_EN_BIT;
        state_nxt = st.k_lt_tree ? S_EN_NEXT : S_OUT;
      end
      S_EN_NEXT: begin
        cmd.op = OP_EN_NEXT;
        state_nxt = (!st.pdat_root && st.len_lt_tree) ? S_EN_BIT : S_OUT;
      end
      S_DE_ROOT: begin cmd.op = OP_DE_ROOT; state_nxt = S_DE_LD; end
      S_DE_LD:   begin cmd.op = OP_DE_LD;   state_nxt = S_DE_CHK; end
      S_DE_CHK: begin
        cmd.op = OP_DE_CHK;
        if (!(st.k_lt_tree && st.len_lt_win)) state_nxt = S_OUT;
        else if (st.kp_lt_tree) state_nxt = S_DE_LD;
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt = (st.mode && st.k_lt_tree) ? S_IDLE : S_U_RROOT;
        end
      end
      S_U_RROOT: begin cmd.op = OP_U_RROOT; state_nxt = S_U_CHKR; end
      S_U_CHKR: begin
        cmd.op = OP_U_CHKR;
        state_nxt = st.need_rebuild ? S_RB1_RD : S_U_LEAF;
      end
      S_U_LEAF: begin cmd.op = OP_U_LEAF; state_nxt = S_U_LDC; end
      S_U_LDC:  begin cmd.op = OP_U_LDC;  state_nxt = S_U_TOP; end
      S_U_TOP: begin
        cmd.op = OP_U_TOP;
        state_nxt = (st.steps_lt_tree && st.k_lt_tree) ? S_U_INC : S_IDLE;
      end
      S_U_INC: begin cmd.op = OP_U_INC; state_nxt = S_U_SCR; end
      S_U_SCR: begin
        cmd.op = OP_U_SCR;
        state_nxt = st.x_lt_root ? S_U_SCC : S_U_SWCHK;
      end
      S_U_SCC: begin
        cmd.op = OP_U_SCC;
        state_nxt = st.f_gt_n ? S_U_SCR : S_U_SWCHK;
      end
      S_U_SWCHK: begin
        cmd.op = OP_U_SWCHK;
        state_nxt = st.x_ne_k ? S_SW_RB : S_U_RCHK;
      end
      S_SW_RB: begin cmd.op = OP_SW_RB; state_nxt = S_SW_W1; end
      S_SW_W1: begin cmd.op = OP_SW_W1; state_nxt = S_SW_W2; end
      S_SW_W2: begin cmd.op = OP_SW_W2; state_nxt = S_SW_W3; end
      S_SW_W3: begin cmd.op = OP_SW_W3; state_nxt = S_SW_W4; end
      S_SW_W4: begin cmd.op = OP_SW_W4; state_nxt = S_U_RCHK; end
      S_U_RCHK: begin
        cmd.op = OP_U_RCHK;
        state_nxt = st.k_is_root ? S_IDLE : S_U_NXT;
      end
      S_U_NXT: begin cmd.op = OP_U_NXT; state_nxt = S_U_TOP; end
      S_RB1_RD: begin cmd.op = OP_RB1_RD; state_nxt = S_RB1_WR; end
      S_RB1_WR: begin
        cmd.op = OP_RB1_WR;
        state_nxt = st.rb_last ? S_RB2_RA : S_RB1_RD;
      end
      S_RB2_RA: begin
        cmd.op = OP_RB2_RA;
        state_nxt = st.e_done ? S_RB3_RD : S_RB2_RB;
      end
      S_RB2_RB:  begin cmd.op = OP_RB2_RB;  state_nxt = S_RB2_SUM; end
      S_RB2_SUM: begin cmd.op = OP_RB2_SUM; state_nxt = S_RB2_ST; end
      S_RB2_ST: begin
        cmd.op = OP_RB2_ST;
        state_nxt = st.j_gt0 ? S_RB2_CMP : S_RB2_PUT;
      end
      S_RB2_CMP: begin
        cmd.op = OP_RB2_CMP;
        state_nxt = st.f_lt_n ? S_RB2_ST : S_RB2_PUT;
      end
      S_RB2_PUT: begin cmd.op = OP_RB2_PUT; state_nxt = S_RB2_RA; end
      S_RB3_RD:  begin cmd.op = OP_RB3_RD;  state_nxt = S_RB3_W1; end
      S_RB3_W1:  begin cmd.op = OP_RB3_W1;  state_nxt = S_RB3_W2; end
      S_RB3_W2: begin
        cmd.op = OP_RB3_W2;
        state_nxt = st.rb_last ? S_RB3_ROOT : S_RB3_RD;
      end
      S_RB3_ROOT: begin cmd.op = OP_RB3_ROOT; state_nxt = S_U_LEAF; end
      default: state_nxt = S_INIT;
    endcase
  end

  // Result valid flag: set on load, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/adaptive_huffman_codec_core.sv =====
// Top level of the adaptive Huffman codec: joins the sequencer and the datapath.
// Depends on ahc_pkg, the channel interfaces, ahc_ctrl and ahc_datapath.
//
// Usage:
//   in_ch takes one word per symbol: symbol_in in encode mode, code_window in decode
//   mode. out_ch returns one word per input: code, length, symbol and a too-long flag.
//   cfg_ch writes the mode bit (0 encode, 1 decode); it is always ready and is to be
//   written only while the block is idle.
// Sequence:
//   Items are processed one at a time. Encode emits one bit per tree level of the
//   symbol's code, walking up from its leaf; decode steps down from the root per bit
//   consumed. The result is then loaded into the output register, and the model
//   update runs: per tree level it increments the count, compares positions in the
//   sibling order and swaps where needed. A rebuild, when the root count reaches its
//   limit, adds a pass that halves the leaf counts, an insertion pass that shifts
//   entries to place each new node, and a pass that relinks the parents.
// Reset and stalls:
//   After reset a clearing pass writes the initial tree layout, during which in_ch
//   is not ready. The next input is accepted while an earlier result waits on out_ch;
//   a new result waits until the output register is free.
`default_nettype none

module adaptive_huffman_codec_core (
  input wire logic  clk,
  input wire logic  rst_n,
  ahc_in_if.sink    in_ch,
  ahc_out_if.source out_ch,
  ahc_cfg_if.sink   cfg_ch
);
  import ahc_pkg::*;

  ahc_cmd_t    cmd;
  ahc_status_t st;

  // Mode writes are taken at any time.
  assign cfg_ch.ready = 1'b1;

  ahc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .st        (st),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  ahc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .symbol_in   (in_ch.symbol_in),
    .code_window (in_ch.code_window),
    .cfg_we      (cfg_ch.valid),
    .cfg_mode    (cfg_ch.mode),
    .code_value  (out_ch.code_value),
    .code_length (out_ch.code_length),
    .symbol_out  (out_ch.symbol_out),
    .too_long    (out_ch.too_long)
  );

endmodule

`default_nettype wire

// ===== sv/ahc_checker.sv =====
// Port-level checks for the adaptive Huffman codec, bound to its top level.
// Depends on ahc_pkg for field widths.
`default_nettype none

module ahc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [ahc_pkg::WINDOW_BITS-1:0] code_value,
  input wire logic [ahc_pkg::LEN_W-1:0]       code_length,
  input wire logic [ahc_pkg::SYM_W-1:0]       symbol_out,
  input wire logic                            too_long
);
  import ahc_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_value) &&
      $stable(code_length) && $stable(symbol_out) && $stable(too_long))
    else $error("result word changed while stalled");

  // The clearing pass after reset keeps the input closed.
  a_init_closed: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  // One item at a time: an accepted word closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  // A too-long result carries no code bits.
  a_long_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && too_long |-> code_length == '0 && code_value == '0)
    else $error("too-long result with code bits");

  // A carried code never exceeds the window.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !too_long |-> code_length <= LEN_W'(WINDOW_BITS))
    else $error("code length beyond window");

endmodule

bind adaptive_huffman_codec_core ahc_checker u_ahc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .code_value  (out_ch.code_value),
  .code_length (out_ch.code_length),
  .symbol_out  (out_ch.symbol_out),
  .too_long    (out_ch.too_long)
);

`default_nettype wire
